// File: rtl/aop_pkg.sv
package aop_pkg;

	localparam int unsigned MaxBoxes  = 64;
	localparam int unsigned IdBits    = $clog2(MaxBoxes);
	localparam int unsigned CountBits = IdBits + 1;
	localparam int unsigned CoordBits = 32;
	localparam int unsigned NumAxes   = 3;
	localparam int unsigned BoxBits   = 2 * NumAxes * CoordBits;
	localparam int unsigned PaddrBits = 3;
	localparam int unsigned DataBits  = 32;

	// Register index of enabled_axes; the index is paddr[2] (byte address 4*i).
	localparam logic RegEnabledAxes = 1'b0;
	localparam logic [NumAxes-1:0] AxesReset = '1;

	typedef struct packed {
		logic [NumAxes-1:0][CoordBits-1:0] lo;
		logic [NumAxes-1:0][CoordBits-1:0] hi;
	} box_t;

	typedef struct packed {
		box_t              box;
		logic [IdBits-1:0] id;
		logic              sweep;
	} cmd_t;

	typedef struct packed {
		logic [IdBits-1:0] lower_id;
		logic [IdBits-1:0] higher_id;
		logic              last_pair;
	} pair_t;

	typedef enum logic [1:0] {
		BkIdle,
		BkSweep,
		BkFlush
	} bk_state_t;

	// Closed intervals: touching bounds count as overlap.
	function automatic logic boxes_meet(box_t a, box_t b, logic [NumAxes-1:0] axes);
		logic ok;
		ok = 1'b1;
		for (int k = 0; k < NumAxes; k++) begin
			if (axes[k]) begin
				if ($signed(a.lo[k]) > $signed(b.hi[k]) || $signed(b.lo[k]) > $signed(a.hi[k]))
					ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

// File: rtl/aop_ram.sv
module aop_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/aop_front.sv
module aop_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  aop_pkg::box_t                box,
	input  logic                         closes_set,
	input  logic [aop_pkg::NumAxes-1:0]  axes,
	output logic                         cmd_valid,
	output aop_pkg::cmd_t                cmd,
	input  logic                         cmd_pop
);

	import aop_pkg::*;

	logic [CountBits-1:0] count_q;
	cmd_t                 mem_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           cnt_q;
	logic                 accept;
	logic                 room;
	logic                 enq;
	cmd_t                 new_cmd;

	assign full      = (cnt_q == 2'd2);
	assign accept    = push && !full;
	assign room      = (count_q < CountBits'(MaxBoxes));
	// A box that finds the set full is taken and dropped without a command.
	assign enq       = accept && room;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = mem_q[rd_ptr_q];

	always_comb begin
		new_cmd.box   = box;
		new_cmd.id    = count_q[IdBits-1:0];
		new_cmd.sweep = (axes != '0) && (count_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (accept) begin
				if (closes_set)
					count_q <= '0;
				else if (room)
					count_q <= count_q + CountBits'(1);
			end
			if (enq)
				wr_ptr_q <= !wr_ptr_q;
			if (cmd_pop)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, enq} - {1'b0, cmd_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= new_cmd;
		end
	end

endmodule

// File: rtl/aop_back.sv
module aop_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  aop_pkg::cmd_t                cmd,
	output logic                         cmd_pop,
	input  logic [aop_pkg::NumAxes-1:0]  axes,
	output logic                         empty,
	input  logic                         pop,
	output aop_pkg::pair_t               pair
);

	import aop_pkg::*;

	bk_state_t         state_q;
	bk_state_t         state_d;
	box_t              box_q;
	logic [IdBits-1:0] id_q;
	logic [IdBits-1:0] j_q;
	logic              rvalid_s1;
	logic [IdBits-1:0] rid_s1;
	logic [IdBits-1:0] pend_q;
	logic              pend_valid_q;

	logic [BoxBits-1:0] ram_rdata;
	box_t               stored;
	logic               hit;
	logic               push_mid;
	logic               res_full;
	logic               stall;
	logic               issue;
	logic               res_push;
	pair_t              res_data;

	pair_t      res_mem_q [2];
	logic       res_wr_q;
	logic       res_rd_q;
	logic [1:0] res_cnt_q;

	aop_ram #(
		.Width(BoxBits),
		.Depth(MaxBoxes)
	) u_store (
		.clk  (clk),
		.we   (cmd_pop),
		.waddr(cmd.id),
		.wdata(cmd.box),
		.re   (issue),
		.raddr(j_q),
		.rdata(ram_rdata)
	);

	assign stored   = box_t'(ram_rdata);
	assign res_full = (res_cnt_q == 2'd2);
	assign empty    = (res_cnt_q == 2'd0);
	assign pair     = res_mem_q[res_rd_q];

	// A hit is held back one step so that the final pair can carry its flag.
	assign hit      = (state_q == BkSweep) && rvalid_s1 && boxes_meet(stored, box_q, axes);
	assign push_mid = hit && pend_valid_q;
	assign stall    = push_mid && res_full;

	always_comb begin
		cmd_pop  = 1'b0;
		issue    = 1'b0;
		res_push = 1'b0;
		res_data = '{lower_id: pend_q, higher_id: id_q, last_pair: 1'b0};
		case (state_q)
			BkIdle: begin
				cmd_pop = cmd_valid;
			end
			BkSweep: begin
				issue    = (j_q != id_q) && !stall;
				res_push = push_mid && !res_full;
			end
			BkFlush: begin
				res_push           = pend_valid_q && !res_full;
				res_data.last_pair = 1'b1;
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BkIdle: begin
				if (cmd_valid && cmd.sweep && cmd.id != '0)
					state_d = BkSweep;
			end
			BkSweep: begin
				if (j_q == id_q && !rvalid_s1)
					state_d = BkFlush;
			end
			BkFlush: begin
				if (!pend_valid_q || !res_full)
					state_d = BkIdle;
			end
			default: begin
				state_d = BkIdle;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BkIdle;
			rvalid_s1    <= 1'b0;
			pend_valid_q <= 1'b0;
			j_q          <= '0;
			res_wr_q     <= 1'b0;
			res_rd_q     <= 1'b0;
			res_cnt_q    <= 2'd0;
		end else begin
			state_q <= state_d;
			if (cmd_pop) begin
				j_q          <= '0;
				rvalid_s1    <= 1'b0;
				pend_valid_q <= 1'b0;
			end else if (state_q == BkSweep && !stall) begin
				rvalid_s1 <= issue;
				if (issue)
					j_q <= j_q + IdBits'(1);
				if (hit)
					pend_valid_q <= 1'b1;
			end else if (state_q == BkFlush && res_push) begin
				pend_valid_q <= 1'b0;
			end
			if (res_push)
				res_wr_q <= !res_wr_q;
			if (pop && !empty)
				res_rd_q <= !res_rd_q;
			res_cnt_q <= res_cnt_q + {1'b0, res_push} - {1'b0, pop && !empty};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			box_q <= cmd.box;
			id_q  <= cmd.id;
		end
		if (state_q == BkSweep && !stall) begin
			rid_s1 <= j_q;
			if (hit)
				pend_q <= rid_s1;
		end
		if (res_push) begin
			res_mem_q[res_wr_q] <= res_data;
		end
	end

endmodule

// File: rtl/aabb_overlap_pair_finder.sv
// Broadphase pair finder for 3D axis-aligned boxes.
// Boxes enter through a queue-like port: a request is taken when push is high
// and full is low. Each box gets the next arrival id of the current set and is
// checked against every earlier box of that set; closes_set ends the set.
// Overlapping pairs leave through a second queue-like port: while empty is low
// the oldest pair sits on lower_id/higher_id/last_pair, and pop takes it.
// last_pair marks the final pair that one box causes.
// A front stage numbers the boxes and holds them in a two-entry command queue;
// the back stage writes each box to the box memory and then reads the earlier
// boxes one per cycle from its single read port, unless a pair finds the result
// queue full. A box that starts a set or meets an empty axis mask is only
// written, not swept, and one that finds the set full is dropped.
// A pair waits for the next hit or the end of the sweep before it is queued.
// If pop stays low, the two-entry result queue fills, the sweep stops, then the
// command queue fills and full rises; nothing is lost.
// Reset empties both queues, starts a new set and sets enabled_axes to 7.
// enabled_axes sits at byte address 0 of the APB port; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module aabb_overlap_pair_finder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [aop_pkg::PaddrBits-1:0]  paddr,
	input  logic [aop_pkg::DataBits-1:0]   pwdata,
	output logic [aop_pkg::DataBits-1:0]   prdata,
	output logic                           pready,
	input  logic                           push,
	output logic                           full,
	input  logic signed [31:0]             min_x,
	input  logic signed [31:0]             min_y,
	input  logic signed [31:0]             min_z,
	input  logic signed [31:0]             max_x,
	input  logic signed [31:0]             max_y,
	input  logic signed [31:0]             max_z,
	input  logic                           closes_set,
	output logic                           empty,
	input  logic                           pop,
	output logic [aop_pkg::IdBits-1:0]     lower_id,
	output logic [aop_pkg::IdBits-1:0]     higher_id,
	output logic                           last_pair
);

	import aop_pkg::*;

	logic [NumAxes-1:0] axes_q;
	logic               cfg_wr;
	box_t               in_box;
	logic               cmd_valid;
	cmd_t               cmd;
	logic               cmd_pop;
	pair_t              pair;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (paddr[2] == RegEnabledAxes)
			prdata[NumAxes-1:0] = axes_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axes_q <= AxesReset;
		end else if (cfg_wr && paddr[2] == RegEnabledAxes) begin
			axes_q <= pwdata[NumAxes-1:0];
		end
	end

	always_comb begin
		in_box.lo[0] = min_x;
		in_box.lo[1] = min_y;
		in_box.lo[2] = min_z;
		in_box.hi[0] = max_x;
		in_box.hi[1] = max_y;
		in_box.hi[2] = max_z;
	end

	aop_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.box       (in_box),
		.closes_set(closes_set),
		.axes      (axes_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	aop_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.axes     (axes_q),
		.empty    (empty),
		.pop      (pop),
		.pair     (pair)
	);

	assign lower_id  = pair.lower_id;
	assign higher_id = pair.higher_id;
	assign last_pair = pair.last_pair;

	// The back stage must never take a command that the front has not queued.
	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command taken from an empty queue");

	// A reported pair always names the earlier box first.
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (lower_id < higher_id))
		else $error("pair ids out of order");

	// A register write lands in the axis mask on the next cycle.
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && paddr[2] == RegEnabledAxes) |=> (axes_q == $past(pwdata[NumAxes-1:0])))
		else $error("axis mask write lost");

endmodule

// File: bench/tb_aabb_overlap_pair_finder.sv
module tb_aabb_overlap_pair_finder;
	timeunit 1ns;
	timeprecision 1ps;

	import aop_pkg::*;

	// Up to three boxes that form no pair may still be in flight, each of them
	// possibly sweeping a full set in the back stage.
	localparam int unsigned SettleCycles  = 240;
	localparam int unsigned HoldOffCycles = 400;
	localparam logic [31:0] MinCoord      = 32'h8000_0000;
	localparam logic [31:0] MaxCoord      = 32'h7FFF_FFFF;

	class overlap_tracker;
		box_t               boxes [MaxBoxes];
		int unsigned        box_count;
		logic [NumAxes-1:0] axes;
		pair_t              awaited_pairs [$];
		int unsigned        mismatches;

		function new();
			box_count = 0;
			axes = AxesReset;
			mismatches = 0;
		endfunction

		function bit overlaps(box_t a, box_t b);
			for (int k = 0; k < NumAxes; k++) begin
				if (axes[k] && !($signed(a.lo[k]) <= $signed(b.hi[k])
						&& $signed(b.lo[k]) <= $signed(a.hi[k])))
					return 1'b0;
			end
			return 1'b1;
		endfunction

		// Stores the box and queues the pairs it forms with the earlier boxes of the set.
		function void take_box(box_t b, logic closes);
			int unsigned earlier;
			int unsigned hits;
			int unsigned seen;
			pair_t p;
			if (box_count < MaxBoxes) begin
				boxes[box_count] = b;
				earlier = (axes != '0) ? box_count : 0;
				hits = 0;
				for (int j = 0; j < earlier; j++)
					if (overlaps(boxes[j], b))
						hits++;
				seen = 0;
				for (int j = 0; j < earlier; j++) begin
					if (overlaps(boxes[j], b)) begin
						seen++;
						p.lower_id = IdBits'(j);
						p.higher_id = IdBits'(box_count);
						p.last_pair = (seen == hits);
						awaited_pairs.push_back(p);
					end
				end
				box_count++;
			end
			if (closes)
				box_count = 0;
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s", $realtime, msg);
		endfunction

		function void check_pair(pair_t got);
			pair_t want;
			if (awaited_pairs.size() == 0) begin
				report($sformatf("unexpected pair %0d/%0d last=%0b",
					got.lower_id, got.higher_id, got.last_pair));
				return;
			end
			want = awaited_pairs.pop_front();
			if (got.lower_id !== want.lower_id || got.higher_id !== want.higher_id
					|| got.last_pair !== want.last_pair)
				report($sformatf("pair mismatch: expected %0d/%0d last=%0b, got %0d/%0d last=%0b",
					want.lower_id, want.higher_id, want.last_pair,
					got.lower_id, got.higher_id, got.last_pair));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PaddrBits-1:0] paddr = '0;
	logic [DataBits-1:0]  pwdata = '0;
	logic [DataBits-1:0]  prdata;
	logic                 pready;
	logic                 push = 1'b0;
	logic                 full;
	logic signed [31:0]   min_x = '0;
	logic signed [31:0]   min_y = '0;
	logic signed [31:0]   min_z = '0;
	logic signed [31:0]   max_x = '0;
	logic signed [31:0]   max_y = '0;
	logic signed [31:0]   max_z = '0;
	logic                 closes_set = 1'b0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [IdBits-1:0]    lower_id;
	logic [IdBits-1:0]    higher_id;
	logic                 last_pair;

	overlap_tracker       tracker;
	bit                   no_idle = 1'b0;
	int unsigned          rx_hold = 0;
	logic [NumAxes-1:0]   mask_plan [8] = '{3'b001, 3'b110, 3'b000, 3'b111,
		3'b010, 3'b101, 3'b100, 3'b011};

	aabb_overlap_pair_finder u_top (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 25);
	endfunction

	function automatic box_t make_box(logic [31:0] lx, ly, lz, hx, hy, hz);
		box_t b;
		b.lo[0] = lx;
		b.lo[1] = ly;
		b.lo[2] = lz;
		b.hi[0] = hx;
		b.hi[1] = hy;
		b.hi[2] = hz;
		return b;
	endfunction

	// Mostly small boxes clustered around the origin so that many of them overlap,
	// with some full-width noise, inverted boxes and boxes spanning the whole range.
	function automatic box_t rand_box(int spread);
		box_t b;
		int unsigned kind;
		int c;
		kind = $urandom_range(99);
		for (int k = 0; k < NumAxes; k++) begin
			if (kind < 8) begin
				b.lo[k] = $urandom();
				b.hi[k] = $urandom();
			end else if (kind >= 96) begin
				b.lo[k] = MinCoord;
				b.hi[k] = MaxCoord;
			end else begin
				c = int'($urandom_range(2 * spread)) - spread;
				c = c * 65536 + int'($urandom_range(65535));
				b.lo[k] = c;
				b.hi[k] = c + int'($urandom_range(12 * 65536));
				if (kind < 12)
					b.lo[k] = b.hi[k] + int'($urandom_range(4 * 65536, 1));
			end
		end
		return b;
	endfunction

	task automatic offer_box(box_t b, logic closes);
		int unsigned gap;
		min_x <= b.lo[0];
		min_y <= b.lo[1];
		min_z <= b.lo[2];
		max_x <= b.hi[0];
		max_y <= b.hi[1];
		max_z <= b.hi[2];
		closes_set <= closes;
		push <= 1'b1;
		do
			@(posedge clk);
		while (full);
		tracker.take_box(b, closes);
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic run_sets(int unsigned count, int spread);
		int unsigned left_in_set;
		left_in_set = 0;
		for (int unsigned n = 0; n < count; n++) begin
			if (left_in_set == 0)
				left_in_set = $urandom_range(8, 1);
			left_in_set--;
			offer_box(rand_box(spread), left_in_set == 0);
		end
	endtask

	// A box that forms no pair may still be in the back stage, hence the extra wait.
	task automatic drain();
		push <= 1'b0;
		do
			@(posedge clk);
		while (tracker.awaited_pairs.size() != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_axes(logic [NumAxes-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {RegEnabledAxes, 2'b00};
		pwdata <= (DataBits'($urandom()) << NumAxes) | DataBits'(value);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.axes = value;
	endtask

	initial begin
		pair_t got;
		int unsigned gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = pick_gap() + rx_hold;
			rx_hold = 0;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			if (!empty) begin
				got.lower_id = lower_id;
				got.higher_id = higher_id;
				got.last_pair = last_pair;
				tracker.check_pair(got);
			end
		end
	end

	initial begin
		tracker = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_axes(3'b111);

		// Touching bounds, the coordinate extremes, an inverted box and negative values.
		offer_box(make_box(0, 0, 0, 32'h000A_0000, 32'h000A_0000, 32'h000A_0000), 1'b0);
		offer_box(make_box(32'h000A_0000, 0, 0, 32'h0014_0000, 32'h000A_0000, 32'h000A_0000),
			1'b0);
		offer_box(make_box(32'h000A_8000, 0, 0, 32'h0014_0000, 32'h000A_0000, 32'h000A_0000),
			1'b0);
		offer_box(make_box(MinCoord, MinCoord, MinCoord, MaxCoord, MaxCoord, MaxCoord), 1'b0);
		offer_box(make_box(MaxCoord, MaxCoord, MaxCoord, MaxCoord, MaxCoord, MaxCoord), 1'b0);
		offer_box(make_box(MinCoord, MinCoord, MinCoord, MinCoord, MinCoord, MinCoord), 1'b0);
		offer_box(make_box(32'h0014_0000, 32'h0014_0000, 32'h0014_0000, 0, 0, 0), 1'b0);
		offer_box(make_box(32'hFFFB_8000, 32'hFFFB_8000, 32'hFFFB_8000,
			32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000), 1'b1);

		// After a closed set the ids start again from zero.
		offer_box(make_box(0, 0, 0, 32'h000A_0000, 32'h000A_0000, 32'h000A_0000), 1'b0);
		offer_box(make_box(0, 0, 32'hFFFD_0000, 32'h000A_0000, 32'h000A_0000, 0), 1'b1);

		// With no axis enabled the boxes still take ids but form no pairs.
		drain();
		write_axes(3'b000);
		offer_box(make_box(0, 0, 0, 32'h000A_0000, 32'h000A_0000, 32'h000A_0000), 1'b0);
		offer_box(make_box(0, 0, 0, 32'h000A_0000, 32'h000A_0000, 32'h000A_0000), 1'b0);
		drain();
		write_axes(3'b111);
		offer_box(make_box(0, 0, 0, 32'h000A_0000, 32'h000A_0000, 32'h000A_0000), 1'b1);

		foreach (mask_plan[i]) begin
			drain();
			write_axes(mask_plan[i]);
			no_idle = (i % 3 == 2);
			run_sets(4, 10);
		end

		// Hold the result side off while heavily overlapping boxes keep coming in.
		drain();
		write_axes(3'b111);
		no_idle = 1'b1;
		rx_hold = HoldOffCycles;
		for (int n = 0; n < 12; n++)
			offer_box(rand_box(0), n == 11);

		// Fill a whole set; the two extra boxes are ignored and the last one closes it.
		drain();
		write_axes(3'b001);
		no_idle = 1'b0;
		for (int n = 0; n < MaxBoxes + 2; n++)
			offer_box(rand_box(40), n == MaxBoxes + 1);

		drain();
		write_axes(3'b111);
		run_sets(4, 10);

		drain();
		if (tracker.mismatches == 0 && tracker.awaited_pairs.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: sim.f
rtl/aop_pkg.sv
rtl/aop_ram.sv
rtl/aop_front.sv
rtl/aop_back.sv
rtl/aabb_overlap_pair_finder.sv
bench/tb_aabb_overlap_pair_finder.sv
